/* hw/rtl/chtr_pkg.sv */
package chtr_pkg;

    localparam int CLUSTERS_DEF = 4096;
    localparam int WAYS_DEF     = 3;

    localparam int TAG_W  = 16;
    localparam int MV_W   = 32;
    localparam int META_W = 26;
    localparam int ENT_W  = TAG_W + MV_W + META_W;

    typedef enum logic [1:0] {
        MODE_PROBE = 2'd0,
        MODE_STORE = 2'd1,
        MODE_NEWS  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;
        logic clr_step;
        logic load_in;
        logic rd;
        logic eval;
        logic wr;
        logic zero_res;
        logic gen_inc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic mode_mem;
        logic mode_gen;
    } t_sts;

endpackage

/* hw/rtl/chtr_ctrl.sv */
module chtr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  chtr_pkg::t_sts i_sts,
    output chtr_pkg::t_cmd o_cmd
);
    import chtr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr   = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                if (i_sts.mode_mem) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_EVAL;
                end else begin
                    o_cmd.zero_res = 1'b1;
                    o_cmd.gen_inc  = i_sts.mode_gen;
                    n_state        = ST_OUT;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    ap_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("accept during clear");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
    ap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("accept while result pending");
endmodule

/* hw/rtl/chtr_dp.sv */
module chtr_dp #(
    parameter int CLUSTERS = chtr_pkg::CLUSTERS_DEF,
    parameter int WAYS     = chtr_pkg::WAYS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_wdata,
    input  logic [67:0]    i_in_data,
    input  chtr_pkg::t_cmd i_cmd,
    output chtr_pkg::t_sts o_sts,
    output logic [79:0]    o_out_data
);
    import chtr_pkg::*;

    localparam int CI_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // one row holds all ways of a cluster
    logic [ENT_W-1:0] mem [CLUSTERS][WAYS];

    logic [1:0]         r_exact;
    logic [7:0]         r_gen;
    logic [CI_W:0]      r_clr;
    logic [67:0]        r_in;
    logic [ENT_W-1:0]   r_row [WAYS];
    logic [ENT_W-1:0]   r_res;
    logic               r_found, r_written;
    logic [1:0]         r_slot;
    logic [7:0]         r_hit;
    logic               r_do_wr;
    logic [ENT_W-1:0]   r_wdata;

    logic [1:0]  in_mode;
    logic [15:0] in_tag, in_value, in_move;
    logic [7:0]  in_depth, in_eval;
    logic [1:0]  in_bound;
    logic [CI_W-1:0] cidx;

    assign in_mode  = r_in[1:0];
    assign in_tag   = r_in[17:2];
    assign in_value = r_in[33:18];
    assign in_depth = r_in[41:34];
    assign in_bound = r_in[43:42];
    assign in_move  = r_in[59:44];
    assign in_eval  = r_in[67:60];
    assign cidx     = (CLUSTERS > 1) ? in_tag[CI_W-1:0] : '0;

    assign o_sts.clr_done = (r_clr >= (CI_W+1)'(CLUSTERS - 1));
    assign o_sts.mode_mem = (in_mode == MODE_PROBE) || (in_mode == MODE_STORE);
    assign o_sts.mode_gen = (in_mode == MODE_NEWS);

    // entry layout: tag[73:58], move[57:42], value[41:26], eval[25:18], gen, depth, bound
    function automatic logic signed [10:0] score(input logic [ENT_W-1:0] e,
                                                  input logic [7:0] g);
        score = $signed({3'b0, e[9:2]}) -
                ($signed({3'b0, g}) - $signed({3'b0, e[17:10]})) * 11'sd2;
    endfunction

    logic [7:0]       hit;
    logic             fnd;
    logic signed [10:0] best;
    logic             skip;
    logic [ENT_W-1:0] sel, nent;

    always_comb begin
        fnd  = 1'b0;
        hit  = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_row[i][73:58] == in_tag) begin
                fnd = 1'b1;
                hit = 8'(i);
            end
        end
        if (!fnd) begin
            best = score(r_row[0], r_gen);
            for (int i = 1; i < WAYS; i++) begin
                if (score(r_row[i], r_gen) < best) begin
                    best = score(r_row[i], r_gen);
                    hit  = 8'(i);
                end
            end
        end else begin
            best = '0;
        end
        sel  = r_row[hit[WI_W-1:0]];
        skip = (sel[73:58] == in_tag) && (sel[9:2] > in_depth) && (in_bound == r_exact);
        if (in_mode == MODE_PROBE) begin
            nent = fnd ? {sel[73:18], r_gen, sel[9:0]} : sel;
        end else if (skip) begin
            nent = sel;
        end else begin
            nent = {in_tag, in_move, in_value, in_eval, r_gen, in_depth, in_bound};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact <= 2'd3;
            r_gen   <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cfg_we) r_exact <= i_cfg_wdata;
            if (i_cmd.gen_inc) r_gen <= r_gen + 8'd1;
            if (i_cmd.clr_step && !o_sts.clr_done) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_data;
        if (i_cmd.rd) begin
            for (int i = 0; i < WAYS; i++) r_row[i] <= mem[cidx][i];
        end
        if (i_cmd.eval) begin
            r_found   <= fnd;
            r_slot    <= hit[1:0];
            r_hit     <= hit;
            r_written <= (in_mode == MODE_STORE) && !skip;
            r_do_wr   <= (in_mode == MODE_STORE) ? !skip : fnd;
            r_wdata   <= nent;
            r_res     <= nent;
        end
        if (i_cmd.zero_res) begin
            r_found   <= 1'b0;
            r_slot    <= '0;
            r_written <= 1'b0;
            r_res     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            for (int i = 0; i < WAYS; i++) mem[r_clr[CI_W-1:0]][i] <= '0;
        end else if (i_cmd.wr && r_do_wr) begin
            for (int i = 0; i < WAYS; i++) begin
                if (r_hit == 8'(i)) mem[cidx][i] <= r_wdata;
            end
        end
    end

    assign o_out_data = {2'b0, r_res[1:0], r_res[9:2], r_res[17:10], r_res[25:18],
                         r_res[41:26], r_res[57:42], r_res[73:58],
                         r_written, r_slot, r_found};

    ap_gen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gen_inc |=> (r_gen == $past(r_gen) + 8'd1))
        else $error("generation step");
    ap_probe_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && in_mode == MODE_PROBE) |=> !r_written)
        else $error("probe wrote");
    ap_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (hit < 8'(WAYS)))
        else $error("slot out of range");
endmodule

/* hw/rtl/clustered_hash_table_replace_core.sv */
// Clustered hash table, three-way replacement.
// s_axis: one operation per transaction, tdata = {mode, key_tag, value, depth,
//   bound, best_move, static_eval} packed from bit 0 (mode lowest).
// m_axis: exactly one result per operation, tdata packed from bit 0:
//   found, slot, written, entry_tag, entry_move, entry_value, entry_eval,
//   entry_gen, entry_depth, entry_bound.
// Config: i_cfg_we/i_cfg_wdata write exact_bound_code (reset 3).
// Probe/store: accept, cluster row read, compare/victim select, write-back,
// result. New search and mode 3: accept, then result, with no table access.
// One item is in flight; the controller takes a new operation only after the
// result of the last one is taken.
// After reset a clearing pass zeroes the table one cluster per cycle, with
// s_axis_tready low. A stalled receiver holds the result and s_axis_tready
// stays low until it is taken.
module clustered_hash_table_replace_core #(
    parameter int CLUSTERS = chtr_pkg::CLUSTERS_DEF,
    parameter int WAYS     = chtr_pkg::WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode, key_tag, value, depth, bound, best_move, static_eval
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // found, slot, written, tag, move, value, eval, gen, depth, bound
);
    import chtr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    chtr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    chtr_dp #(.CLUSTERS(CLUSTERS), .WAYS(WAYS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata[67:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (m_axis_tdata)
    );
endmodule
